### hw/rtl/bba_pkg.sv
// shared constants, types and helpers for the buddy block allocator
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   localparam int MAX_UNITS = 1024;

   // largest pool order that fits the tree
   localparam int ORDER_MAX = $clog2(MAX_UNITS + 1) - 1;
   localparam int RESET_ORDER = (10 > ORDER_MAX) ? ORDER_MAX : 10;
   localparam int TREE_NODES = 2 * MAX_UNITS - 1;
   localparam int NODE_W = $clog2(TREE_NODES);

   // field widths of the request, response and pool order write
   localparam int MODE_W = 2;
   localparam int SIZE_W = 11;
   localparam int OFFSET_W = 10;
   localparam int STATUS_W = 3;
   localparam int ORDER_W = 4;

   // bit length helper input width, and width of orders, depths and node codes
   localparam int BL_W = (SIZE_W > NODE_W + 1) ? SIZE_W : NODE_W + 1;
   localparam int LVL_W = $clog2(BL_W + 2);

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NO_SPACE  = 3'd1,
      STAT_BAD_SIZE  = 3'd2,
      STAT_RANGE     = 3'd3,
      STAT_NOT_ALLOC = 3'd4
   } stat_code_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_ROOT_WAIT,
      S_DESC_WAIT,
      S_MARK,
      S_UP_WAIT,
      S_REF_WAIT,
      S_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLR_INIT,
      DP_CLR_STEP,
      DP_LOAD,
      DP_RD_ROOT,
      DP_RD_LEAF,
      DP_RD_LEFT,
      DP_DESCEND,
      DP_MARK,
      DP_RESTORE,
      DP_CAPTURE,
      DP_CLIMB,
      DP_MERGE,
      DP_RESP_OK,
      DP_RESP_ERR
   } dp_op_type;

   typedef struct packed {
      dp_op_type     op;
      stat_code_type err;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     clr_last;
      logic     req_zero;
      logic     k_over;
      logic     off_over;
      logic     root_short;
      logic     at_target;
      logic     next_at_target;
      logic     node_zero;
      logic     at_root;
      logic     parent_root;
   } dp_stat_type;

   // number of significant bits of v
   function automatic logic [LVL_W-1:0] bit_len(input logic [BL_W-1:0] v);
      logic [LVL_W-1:0] n;
      n = '0;
      for (int i = 0; i < BL_W; i++) begin
         if (v[i]) begin
            n = LVL_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/bba_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
   parameter int Width = 4,
   parameter int Depth = 2047
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### hw/rtl/bba_ctrl.sv
// controller state machine sequencing tree walks of the allocator
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 csr_wr_en,
   input  wire bba_pkg::dp_stat_type stat,
   output bba_pkg::dp_cmd_type       cmd,
   output logic                      busy
);

   bba_pkg::state_type state_ff;
   bba_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd.op = bba_pkg::DP_NOP;
      cmd.err = bba_pkg::STAT_OK;
      unique case (state_ff)
         bba_pkg::S_CLEAR: begin
            cmd.op = bba_pkg::DP_CLR_STEP;
            if (stat.clr_last) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_IDLE: begin
            if (start) begin
               cmd.op = bba_pkg::DP_LOAD;
               state_in = bba_pkg::S_DECODE;
            end
         end
         bba_pkg::S_DECODE: begin
            unique case (stat.mode)
               bba_pkg::MODE_ALLOC: begin
                  priority if (stat.req_zero) begin
                     cmd.op = bba_pkg::DP_RESP_ERR;
                     cmd.err = bba_pkg::STAT_BAD_SIZE;
                     state_in = bba_pkg::S_IDLE;
                  end else if (stat.k_over) begin
                     cmd.op = bba_pkg::DP_RESP_ERR;
                     cmd.err = bba_pkg::STAT_NO_SPACE;
                     state_in = bba_pkg::S_IDLE;
                  end else begin
                     cmd.op = bba_pkg::DP_RD_ROOT;
                     state_in = bba_pkg::S_ROOT_WAIT;
                  end
               end
               bba_pkg::MODE_FREE, bba_pkg::MODE_QUERY: begin
                  if (stat.off_over) begin
                     cmd.op = bba_pkg::DP_RESP_ERR;
                     cmd.err = bba_pkg::STAT_RANGE;
                     state_in = bba_pkg::S_IDLE;
                  end else begin
                     cmd.op = bba_pkg::DP_RD_LEAF;
                     state_in = bba_pkg::S_UP_WAIT;
                  end
               end
               bba_pkg::MODE_RSVD: begin
                  cmd.op = bba_pkg::DP_RESP_ERR;
                  cmd.err = bba_pkg::STAT_BAD_SIZE;
                  state_in = bba_pkg::S_IDLE;
               end
               default: begin
                  state_in = bba_pkg::S_IDLE;
               end
            endcase
         end
         bba_pkg::S_ROOT_WAIT: begin
            priority if (stat.root_short) begin
               cmd.op = bba_pkg::DP_RESP_ERR;
               cmd.err = bba_pkg::STAT_NO_SPACE;
               state_in = bba_pkg::S_IDLE;
            end else if (stat.at_target) begin
               state_in = bba_pkg::S_MARK;
            end else begin
               cmd.op = bba_pkg::DP_RD_LEFT;
               state_in = bba_pkg::S_DESC_WAIT;
            end
         end
         bba_pkg::S_DESC_WAIT: begin
            cmd.op = bba_pkg::DP_DESCEND;
            if (stat.next_at_target) begin
               state_in = bba_pkg::S_MARK;
            end
         end
         bba_pkg::S_MARK: begin
            cmd.op = bba_pkg::DP_MARK;
            state_in = stat.at_root ? bba_pkg::S_DONE : bba_pkg::S_REF_WAIT;
         end
         bba_pkg::S_UP_WAIT: begin
            // nearest used node at or above the leaf is the covering block
            priority if (stat.node_zero) begin
               if (stat.mode == bba_pkg::MODE_FREE) begin
                  cmd.op = bba_pkg::DP_RESTORE;
                  state_in = stat.at_root ? bba_pkg::S_DONE : bba_pkg::S_REF_WAIT;
               end else begin
                  cmd.op = bba_pkg::DP_CAPTURE;
                  state_in = bba_pkg::S_DONE;
               end
            end else if (stat.at_root) begin
               cmd.op = bba_pkg::DP_RESP_ERR;
               cmd.err = bba_pkg::STAT_NOT_ALLOC;
               state_in = bba_pkg::S_IDLE;
            end else begin
               cmd.op = bba_pkg::DP_CLIMB;
            end
         end
         bba_pkg::S_REF_WAIT: begin
            cmd.op = bba_pkg::DP_MERGE;
            if (stat.parent_root) begin
               state_in = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_DONE: begin
            cmd.op = bba_pkg::DP_RESP_OK;
            state_in = bba_pkg::S_IDLE;
         end
         default: begin
            state_in = bba_pkg::S_CLEAR;
         end
      endcase
      // a pool order write restarts the clearing sweep
      if (csr_wr_en) begin
         cmd.op = bba_pkg::DP_CLR_INIT;
         cmd.err = bba_pkg::STAT_OK;
         state_in = bba_pkg::S_CLEAR;
      end
   end

   assign busy = (state_ff != bba_pkg::S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/bba_datapath.sv
// datapath: tree memory, walk registers, node code arithmetic and response registers
`timescale 1ns / 1ps
`default_nettype none

module bba_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bba_pkg::dp_cmd_type               cmd,
   output bba_pkg::dp_stat_type                   stat,
   input  wire logic                              csr_wr_en,
   input  wire logic [bba_pkg::ORDER_W-1:0]       csr_wr_data,
   input  wire logic [bba_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [bba_pkg::SIZE_W-1:0]        req_request_size,
   input  wire logic [bba_pkg::OFFSET_W-1:0]      req_unit_offset,
   output logic                                   rsp_valid,
   output logic      [bba_pkg::STATUS_W-1:0]      rsp_status,
   output logic      [bba_pkg::OFFSET_W-1:0]      rsp_block_offset,
   output logic      [bba_pkg::SIZE_W-1:0]        rsp_block_units
);

   localparam int NW = bba_pkg::NODE_W;
   localparam int LW = bba_pkg::LVL_W;

   // control registers
   logic [LW-1:0] pool_ff, pool_in;
   logic [NW-1:0] clr_idx_ff, clr_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // walk and payload registers
   bba_pkg::mode_type      mode_ff, mode_in;
   logic                   req_zero_ff, req_zero_in;
   logic                   off_over_ff, off_over_in;
   logic [LW-1:0]          k_ff, k_in;
   logic [NW-1:0]          idx_ff, idx_in;
   logic [LW-1:0]          depth_ff, depth_in;
   logic [LW-1:0]          cur_ff, cur_in;
   logic [bba_pkg::OFFSET_W-1:0] hold_off_ff, hold_off_in;
   logic [bba_pkg::SIZE_W-1:0]   hold_units_ff, hold_units_in;
   bba_pkg::stat_code_type rsp_status_ff, rsp_status_in;
   logic [bba_pkg::OFFSET_W-1:0] rsp_off_ff, rsp_off_in;
   logic [bba_pkg::SIZE_W-1:0]   rsp_units_ff, rsp_units_in;

   // tree memory ports
   logic          wr_en;
   logic [NW-1:0] wr_addr;
   logic [LW-1:0] wr_data;
   logic [NW-1:0] rd_addr;
   logic [LW-1:0] rd_data;

   // helpers
   logic [LW-1:0]             csr_order;
   logic [NW-1:0]             pool_units;
   logic [NW-1:0]             leaf_idx;
   logic [bba_pkg::SIZE_W-1:0] size_m1;
   logic [NW-1:0]             parent_idx;
   logic [NW-1:0]             sib_idx;
   logic [NW-1:0]             left_idx;
   logic [NW-1:0]             next_idx;
   logic [LW-1:0]             target;
   logic [LW-1:0]             blk_k;
   logic [NW-1:0]             level_pos;
   logic [NW-1:0]             blk_off;
   logic [LW-1:0]             child_full;
   logic [LW-1:0]             merged;
   logic [LW-1:0]             clr_code;
   logic [LW:0]               need;

   bba_ram #(
      .Width(LW),
      .Depth(bba_pkg::TREE_NODES)
   ) u_tree (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      csr_order = (LW'(csr_wr_data) > LW'(bba_pkg::ORDER_MAX)) ?
                  LW'(bba_pkg::ORDER_MAX) : LW'(csr_wr_data);
      pool_units = NW'(1) << pool_ff;
      leaf_idx = NW'(req_unit_offset) + pool_units - NW'(1);
      size_m1 = req_request_size - bba_pkg::SIZE_W'(1);
      parent_idx = (idx_ff - NW'(1)) >> 1;
      sib_idx = idx_ff[0] ? (idx_ff + NW'(1)) : (idx_ff - NW'(1));
      left_idx = {idx_ff[NW-2:0], 1'b1};
      need = {1'b0, k_ff} + (LW + 1)'(1);
      next_idx = ({1'b0, rd_data} >= need) ? left_idx : (left_idx + NW'(1));
      target = pool_ff - k_ff;
      // covering block of the current node and its first unit
      blk_k = pool_ff - depth_ff;
      level_pos = idx_ff + NW'(1) - (NW'(1) << depth_ff);
      blk_off = level_pos << blk_k;
      // code of a wholly free child at the current depth
      child_full = pool_ff - depth_ff + LW'(1);
      if (cur_ff == child_full && rd_data == child_full) begin
         merged = child_full + LW'(1);
      end else begin
         merged = (cur_ff > rd_data) ? cur_ff : rd_data;
      end
      clr_code = pool_ff + LW'(2) -
                 bba_pkg::bit_len(bba_pkg::BL_W'(clr_idx_ff) + bba_pkg::BL_W'(1));
   end

   always_comb begin
      pool_in = pool_ff;
      clr_idx_in = clr_idx_ff;
      rsp_valid_in = 1'b0;
      mode_in = mode_ff;
      req_zero_in = req_zero_ff;
      off_over_in = off_over_ff;
      k_in = k_ff;
      idx_in = idx_ff;
      depth_in = depth_ff;
      cur_in = cur_ff;
      hold_off_in = hold_off_ff;
      hold_units_in = hold_units_ff;
      rsp_status_in = rsp_status_ff;
      rsp_off_in = rsp_off_ff;
      rsp_units_in = rsp_units_ff;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = '0;
      rd_addr = idx_ff;

      unique case (cmd.op)
         bba_pkg::DP_NOP: begin
         end
         bba_pkg::DP_CLR_INIT: begin
            clr_idx_in = '0;
         end
         bba_pkg::DP_CLR_STEP: begin
            wr_en = 1'b1;
            wr_addr = clr_idx_ff;
            wr_data = clr_code;
            clr_idx_in = clr_idx_ff + NW'(1);
         end
         bba_pkg::DP_LOAD: begin
            mode_in = bba_pkg::mode_type'(req_mode);
            req_zero_in = (req_request_size == '0);
            off_over_in = (NW'(req_unit_offset) >= pool_units);
            k_in = bba_pkg::bit_len(bba_pkg::BL_W'(size_m1));
            if (bba_pkg::mode_type'(req_mode) == bba_pkg::MODE_ALLOC) begin
               idx_in = '0;
               depth_in = '0;
            end else begin
               idx_in = leaf_idx;
               depth_in = pool_ff;
            end
         end
         bba_pkg::DP_RD_ROOT: begin
            rd_addr = '0;
         end
         bba_pkg::DP_RD_LEAF: begin
            rd_addr = idx_ff;
         end
         bba_pkg::DP_RD_LEFT: begin
            rd_addr = left_idx;
         end
         bba_pkg::DP_DESCEND: begin
            // prefer the left child when it can hold the block
            idx_in = next_idx;
            depth_in = depth_ff + LW'(1);
            rd_addr = {next_idx[NW-2:0], 1'b1};
         end
         bba_pkg::DP_MARK, bba_pkg::DP_RESTORE, bba_pkg::DP_CAPTURE: begin
            hold_off_in = bba_pkg::OFFSET_W'(blk_off);
            hold_units_in = bba_pkg::SIZE_W'(1) << blk_k;
            if (cmd.op == bba_pkg::DP_MARK) begin
               wr_en = 1'b1;
               wr_data = '0;
               cur_in = '0;
            end else if (cmd.op == bba_pkg::DP_RESTORE) begin
               wr_en = 1'b1;
               wr_data = child_full;
               cur_in = child_full;
            end
            wr_addr = idx_ff;
            rd_addr = sib_idx;
         end
         bba_pkg::DP_CLIMB: begin
            idx_in = parent_idx;
            depth_in = depth_ff - LW'(1);
            rd_addr = parent_idx;
         end
         bba_pkg::DP_MERGE: begin
            // parent gets the merged code, then its own buddy is fetched
            wr_en = 1'b1;
            wr_addr = parent_idx;
            wr_data = merged;
            cur_in = merged;
            idx_in = parent_idx;
            depth_in = depth_ff - LW'(1);
            rd_addr = parent_idx[0] ? (parent_idx + NW'(1)) : (parent_idx - NW'(1));
         end
         bba_pkg::DP_RESP_OK: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = bba_pkg::STAT_OK;
            rsp_off_in = hold_off_ff;
            rsp_units_in = hold_units_ff;
         end
         bba_pkg::DP_RESP_ERR: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = cmd.err;
            rsp_off_in = '0;
            rsp_units_in = '0;
         end
         default: begin
         end
      endcase

      if (csr_wr_en) begin
         pool_in = csr_order;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= LW'(bba_pkg::RESET_ORDER);
         clr_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_ff <= pool_in;
         clr_idx_ff <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      req_zero_ff <= req_zero_in;
      off_over_ff <= off_over_in;
      k_ff <= k_in;
      idx_ff <= idx_in;
      depth_ff <= depth_in;
      cur_ff <= cur_in;
      hold_off_ff <= hold_off_in;
      hold_units_ff <= hold_units_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff <= rsp_off_in;
      rsp_units_ff <= rsp_units_in;
   end

   always_comb begin
      stat.mode = mode_ff;
      stat.clr_last = (clr_idx_ff == NW'(bba_pkg::TREE_NODES - 1));
      stat.req_zero = req_zero_ff;
      stat.k_over = (k_ff > pool_ff);
      stat.off_over = off_over_ff;
      stat.root_short = ({1'b0, rd_data} < need);
      stat.at_target = (depth_ff == target);
      stat.next_at_target = ((depth_ff + LW'(1)) == target);
      stat.node_zero = (rd_data == '0);
      stat.at_root = (idx_ff == '0);
      stat.parent_root = (idx_ff <= NW'(2));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = bba_pkg::STATUS_W'(rsp_status_ff);
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_block_units = rsp_units_ff;

endmodule

`default_nettype wire

### hw/rtl/buddy_block_allocator_core.sv
// top level of the binary buddy block allocator
//
//   channel   ports                                      transfer when
//   request   start busy req_mode req_request_size       start & !busy
//             req_unit_offset
//   response  rsp_valid rsp_status rsp_block_offset      rsp_valid (one cycle)
//             rsp_block_units
//   config    csr_wr_en csr_wr_data                      csr_wr_en
//
// one response per request, one tree level walked per cycle: an allocate of 2^k
// units descends from the root and refreshes every ancestor, a free climbs to
// the covering block and merges upward, a query climbs to the covering block
// reset and every pool order write run a clearing sweep of all 2047 tree nodes, busy high
// rsp_valid cannot be held off; a new request may start in the response cycle
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [bba_pkg::MODE_W-1:0]        req_mode,
   input  wire logic [bba_pkg::SIZE_W-1:0]        req_request_size,
   input  wire logic [bba_pkg::OFFSET_W-1:0]      req_unit_offset,
   output logic                                   rsp_valid,
   output logic      [bba_pkg::STATUS_W-1:0]      rsp_status,
   output logic      [bba_pkg::OFFSET_W-1:0]      rsp_block_offset,
   output logic      [bba_pkg::SIZE_W-1:0]        rsp_block_units,
   input  wire logic                              csr_wr_en,
   input  wire logic [bba_pkg::ORDER_W-1:0]       csr_wr_data
);

   bba_pkg::dp_cmd_type  cmd;
   bba_pkg::dp_stat_type stat;

   bba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .csr_wr_en(csr_wr_en),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   bba_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_mode        (req_mode),
      .req_request_size(req_request_size),
      .req_unit_offset (req_unit_offset),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_block_offset(rsp_block_offset),
      .rsp_block_units (rsp_block_units)
   );

endmodule

`default_nettype wire

### verif/tb.sv
// self-checking testbench for the buddy block allocator core
`timescale 1ns / 1ps

module tb;
   import bba_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 200;
   localparam int DIRECTED_ROWS = 28;

   typedef struct packed {
      stat_code_type        status;
      logic [OFFSET_W-1:0]  boff;
      logic [SIZE_W-1:0]    units;
   } alloc_result_t;

   typedef struct packed {
      logic [OFFSET_W-1:0]  boff;
      logic [SIZE_W-1:0]    units;
   } live_block_t;

   typedef enum bit {ROW_ITEM, ROW_POOL} row_kind_t;
   typedef enum bit {CHK_MODEL, CHK_FIXED} row_check_t;

   typedef struct packed {
      row_kind_t            kind;
      logic [ORDER_W-1:0]   pool;
      mode_type             mode;
      logic [SIZE_W-1:0]    req_size;
      logic [OFFSET_W-1:0]  off;
      row_check_t           chk;
      stat_code_type        st;
      logic [OFFSET_W-1:0]  boff;
      logic [SIZE_W-1:0]    units;
   } step_row_t;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [MODE_W-1:0]    req_mode = '0;
   logic [SIZE_W-1:0]    req_request_size = '0;
   logic [OFFSET_W-1:0]  req_unit_offset = '0;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [OFFSET_W-1:0]  rsp_block_offset;
   logic [SIZE_W-1:0]    rsp_block_units;
   logic                 csr_wr_en = 1'b0;
   logic [ORDER_W-1:0]   csr_wr_data = '0;

   buddy_block_allocator_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_request_size (req_request_size),
      .req_unit_offset  (req_unit_offset),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset),
      .rsp_block_units  (rsp_block_units),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // mirror of the free tree and pool order
   logic [3:0]      free_codes [0:TREE_NODES-1];
   int unsigned     pool_order_m;
   live_block_t     live_blocks [$];
   alloc_result_t   expected_results [$];
   alloc_result_t   oldest_result;
   int              mismatch_count = 0;
   int              stall_cycles = 0;
   step_row_t       directed_rows [0:DIRECTED_ROWS-1];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void load_pool_order(int unsigned v);
      int unsigned d, i;
      pool_order_m = (v > ORDER_MAX) ? ORDER_MAX : v;
      for (d = 0; d <= pool_order_m; d++) begin
         for (i = (1 << d) - 1; i <= (2 << d) - 2; i++) begin
            free_codes[i] = 4'(pool_order_m - d + 1);
         end
      end
      live_blocks.delete();
   endfunction

   // recompute every ancestor of a changed node, merging wholly free buddies
   function automatic void refresh_ancestors(int unsigned idx, int unsigned d);
      int unsigned full;
      logic [3:0] l, r;
      while (idx != 0) begin
         idx = (idx - 1) / 2;
         d--;
         full = pool_order_m - d;
         l = free_codes[2 * idx + 1];
         r = free_codes[2 * idx + 2];
         if (l == full && r == full) begin
            free_codes[idx] = 4'(full + 1);
         end else begin
            free_codes[idx] = (l > r) ? l : r;
         end
      end
   endfunction

   function automatic alloc_result_t predict_response(mode_type m, logic [SIZE_W-1:0] s,
                                                       logic [OFFSET_W-1:0] o);
      alloc_result_t res;
      int unsigned k, idx, d, depth, lc, pool;
      bit found;
      live_block_t blk;
      res.status = STAT_OK;
      res.boff = '0;
      res.units = '0;
      pool = 1 << pool_order_m;
      case (m)
         MODE_ALLOC: begin
            if (s == 0) begin
               res.status = STAT_BAD_SIZE;
            end else begin
               k = 0;
               while ((1 << k) < s) k++;
               if (k > pool_order_m || free_codes[0] < k + 1) begin
                  res.status = STAT_NO_SPACE;
               end else begin
                  idx = 0;
                  depth = pool_order_m - k;
                  for (d = 0; d < depth; d++) begin
                     lc = 2 * idx + 1;
                     idx = (free_codes[lc] >= k + 1) ? lc : lc + 1;
                  end
                  free_codes[idx] = '0;
                  res.boff = OFFSET_W'((idx + 1 - (1 << depth)) << k);
                  res.units = SIZE_W'(1 << k);
                  refresh_ancestors(idx, depth);
                  blk.boff = res.boff;
                  blk.units = res.units;
                  live_blocks.push_back(blk);
               end
            end
         end
         MODE_FREE, MODE_QUERY: begin
            if (o >= pool) begin
               res.status = STAT_RANGE;
            end else begin
               idx = o + pool - 1;
               d = pool_order_m;
               found = 1'b1;
               // climb to the nearest used node, that is the covering block
               while (free_codes[idx] != 0) begin
                  if (idx == 0) begin
                     found = 1'b0;
                     break;
                  end
                  idx = (idx - 1) / 2;
                  d--;
               end
               if (!found) begin
                  res.status = STAT_NOT_ALLOC;
               end else begin
                  k = pool_order_m - d;
                  res.units = SIZE_W'(1 << k);
                  res.boff = OFFSET_W'((idx + 1 - (1 << d)) << k);
                  if (m == MODE_FREE) begin
                     free_codes[idx] = 4'(k + 1);
                     refresh_ancestors(idx, d);
                     for (int j = 0; j < live_blocks.size(); j++) begin
                        if (live_blocks[j].boff == res.boff) begin
                           live_blocks.delete(j);
                           break;
                        end
                     end
                  end
               end
            end
         end
         default: res.status = STAT_BAD_SIZE;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // start stays high across back-to-back transfers
   task automatic send_item(mode_type m, logic [SIZE_W-1:0] s, logic [OFFSET_W-1:0] o,
                            bit fixed, alloc_result_t fixed_res);
      alloc_result_t pred;
      start <= 1'b1;
      req_mode <= m;
      req_request_size <= s;
      req_unit_offset <= o;
      do @(posedge clock); while (busy);
      pred = predict_response(m, s, o);
      expected_results.push_back(fixed ? fixed_res : pred);
   endtask

   task automatic idle_gap(int pct);
      int n;
      if ($urandom_range(0, 99) < pct) begin
         n = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // only written with nothing outstanding; the write restarts the clearing sweep
   task automatic apply_pool_order(logic [ORDER_W-1:0] v);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      load_pool_order(v);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_random_phase(int count, int pct);
      mode_type m;
      logic [SIZE_W-1:0] s;
      logic [OFFSET_W-1:0] o;
      int pick, k;
      live_block_t blk;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         m = MODE_ALLOC;
         s = $urandom_range(0, 2047);
         o = $urandom_range(0, 1023);
         if (pick < 45) begin
            k = $urandom_range(0, pool_order_m);
            s = $urandom_range(1, 1 << k);
         end else if (pick < 50) begin
            // allocates here keep their full random size, which may be zero or oversize
         end else if (pick < 90 && live_blocks.size() != 0) begin
            blk = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            m = (pick < 78) ? MODE_FREE : MODE_QUERY;
            o = blk.boff + OFFSET_W'($urandom_range(0, blk.units - 1));
         end else if (pick < 96) begin
            m = $urandom_range(0, 1) ? MODE_FREE : MODE_QUERY;
         end else begin
            m = MODE_RSVD;
         end
         send_item(m, s, o, 1'b0, '0);
         idle_gap(pct);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response with nothing outstanding, status", rsp_status, 0);
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_status !== oldest_result.status)
               report_mismatch("status", rsp_status, oldest_result.status);
            if (rsp_block_offset !== oldest_result.boff)
               report_mismatch("block_offset", rsp_block_offset, oldest_result.boff);
            if (rsp_block_units !== oldest_result.units)
               report_mismatch("block_units", rsp_block_units, oldest_result.units);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("buddy_block_allocator_core test failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned phase_orders [0:PHASE_COUNT-1];
      int pct;
      alloc_result_t fixed_res;
      phase_orders = '{3, 10, 1, 15, 6, 0, 2, 8, 4, 10};
      phase_orders[7] = $urandom_range(0, 15);
      directed_rows = '{
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd0,    10'd0,    CHK_FIXED, STAT_BAD_SIZE,  10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd2047, 10'd0,    CHK_FIXED, STAT_NO_SPACE,  10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd1025, 10'd0,    CHK_FIXED, STAT_NO_SPACE,  10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_FREE,  11'd0,    10'd0,    CHK_FIXED, STAT_NOT_ALLOC, 10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_QUERY, 11'd0,    10'd1023, CHK_FIXED, STAT_NOT_ALLOC, 10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_RSVD,  11'd2047, 10'd1023, CHK_FIXED, STAT_BAD_SIZE,  10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd1024, 10'd0,    CHK_FIXED, STAT_OK,        10'd0, 11'd1024},
         '{ROW_ITEM, 4'd0,  MODE_QUERY, 11'd0,    10'd1023, CHK_FIXED, STAT_OK,        10'd0, 11'd1024},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd1,    10'd0,    CHK_FIXED, STAT_NO_SPACE,  10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_FREE,  11'd0,    10'd517,  CHK_FIXED, STAT_OK,        10'd0, 11'd1024},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd1,    10'd0,    CHK_FIXED, STAT_OK,        10'd0, 11'd1},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd3,    10'd0,    CHK_MODEL, STAT_OK,        10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd1,    10'd0,    CHK_MODEL, STAT_OK,        10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd2,    10'd0,    CHK_MODEL, STAT_OK,        10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_QUERY, 11'd0,    10'd5,    CHK_MODEL, STAT_OK,        10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_FREE,  11'd0,    10'd1,    CHK_MODEL, STAT_OK,        10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_FREE,  11'd0,    10'd1,    CHK_FIXED, STAT_NOT_ALLOC, 10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd512,  10'd0,    CHK_MODEL, STAT_OK,        10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_FREE,  11'd0,    10'd700,  CHK_MODEL, STAT_OK,        10'd0, 11'd0},
         '{ROW_POOL, 4'd15, MODE_ALLOC, 11'd0,    10'd0,    CHK_MODEL, STAT_OK,        10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd1024, 10'd0,    CHK_FIXED, STAT_OK,        10'd0, 11'd1024},
         '{ROW_POOL, 4'd0,  MODE_ALLOC, 11'd0,    10'd0,    CHK_MODEL, STAT_OK,        10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_QUERY, 11'd0,    10'd1,    CHK_FIXED, STAT_RANGE,     10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_FREE,  11'd0,    10'd1023, CHK_FIXED, STAT_RANGE,     10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd2,    10'd0,    CHK_FIXED, STAT_NO_SPACE,  10'd0, 11'd0},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd1,    10'd0,    CHK_FIXED, STAT_OK,        10'd0, 11'd1},
         '{ROW_ITEM, 4'd0,  MODE_FREE,  11'd0,    10'd0,    CHK_FIXED, STAT_OK,        10'd0, 11'd1},
         '{ROW_ITEM, 4'd0,  MODE_ALLOC, 11'd1024, 10'd0,    CHK_FIXED, STAT_NO_SPACE,  10'd0, 11'd0}
      };
      load_pool_order(RESET_ORDER);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_POOL) begin
            apply_pool_order(directed_rows[i].pool);
         end else begin
            fixed_res.status = directed_rows[i].st;
            fixed_res.boff = directed_rows[i].boff;
            fixed_res.units = directed_rows[i].units;
            send_item(directed_rows[i].mode, directed_rows[i].req_size, directed_rows[i].off,
                      directed_rows[i].chk == CHK_FIXED, fixed_res);
            idle_gap(30);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         apply_pool_order(4'(phase_orders[p]));
         case ($urandom_range(0, 2))
            0: pct = 0;
            1: pct = 25;
            default: pct = 60;
         endcase
         // no idling in the closing phase
         if (p == PHASE_COUNT - 1) pct = 0;
         run_random_phase(PHASE_ITEMS, pct);
      end

      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("buddy_block_allocator_core test passed");
      end else begin
         $display("buddy_block_allocator_core test failed");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_datapath.sv
hw/rtl/buddy_block_allocator_core.sv
verif/tb.sv
